FILE: rtl/pcc_pkg.sv
`timescale 1ns / 1ps

package pcc_pkg;

  // Request codes on the input channel
  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_READ = 1'b1
  } op_e;

  // Result kinds on the output channel
  typedef enum logic {
    KIND_CLASS = 1'b0,
    KIND_COUNT = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    L4_NOT_IP   = 3'd0,
    L4_IP_OTHER = 3'd1,
    L4_TCP      = 3'd2,
    L4_UDP      = 3'd3,
    L4_ICMP     = 3'd4
  } l4_class_e;

  typedef enum logic [2:0] {
    APP_NONE = 3'd0,
    APP_HTTP = 3'd1,
    APP_FTP  = 3'd2,
    APP_SSH  = 3'd3,
    APP_DNS  = 3'd4
  } app_class_e;

  typedef struct packed {
    l4_class_e  l4;
    app_class_e app;
  } cls_t;

  // Counter rows: packets in the low half, bytes in the high half
  localparam int unsigned NUM_ROWS = 8;
  typedef logic [$clog2(NUM_ROWS)-1:0] row_t;

  localparam row_t ROW_ALL  = 3'd0;
  localparam row_t ROW_TCP  = 3'd1;
  localparam row_t ROW_UDP  = 3'd2;
  localparam row_t ROW_ICMP = 3'd3;
  localparam row_t ROW_FTP  = 3'd4;
  localparam row_t ROW_SSH  = 3'd5;
  localparam row_t ROW_DNS  = 3'd6;
  localparam row_t ROW_HTTP = 3'd7;

  localparam int unsigned LEN_W = 16;

  // One read-modify-write of a counter row
  typedef struct packed {
    logic             valid;
    row_t             row;
    logic [LEN_W-1:0] len;
  } upd_req_t;

endpackage

FILE: rtl/pcc_if.sv
`timescale 1ns / 1ps

interface pcc_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;
  logic       last;
  logic [15:0] frame_len;
  logic [3:0] counter_index;

  modport source (output valid, op, data_byte, last, frame_len, counter_index, input ready);
  modport sink   (input valid, op, data_byte, last, frame_len, counter_index, output ready);
endinterface

interface pcc_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  l4_class;
  logic [2:0]  app_class;
  logic [31:0] count_value;

  modport source (output valid, kind, l4_class, app_class, count_value, input ready);
  modport sink   (input valid, kind, l4_class, app_class, count_value, output ready);
endinterface

FILE: rtl/pcc_parser.sv
`timescale 1ns / 1ps

module pcc_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         byte_en_i,
  input  logic [7:0]   data_byte_i,
  input  logic         last_i,
  output pcc_pkg::cls_t cls_o
);
  import pcc_pkg::*;

  localparam logic [6:0]  POS_MAX     = 7'd127;
  localparam logic [6:0]  POS_ETH_HI  = 7'd12;
  localparam logic [6:0]  POS_ETH_LO  = 7'd13;
  localparam logic [6:0]  POS_IHL     = 7'd14;
  localparam logic [6:0]  POS_PROTO   = 7'd23;
  localparam logic [7:0]  IP_HDR_BASE = 8'd14;
  localparam logic [7:0]  CNT_ETH     = 8'd14;
  localparam logic [7:0]  CNT_PROTO   = 8'd24;
  localparam logic [15:0] ETH_IPV4    = 16'h0800;
  localparam logic [7:0]  PROTO_TCP   = 8'd6;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;
  localparam logic [7:0]  PROTO_ICMP  = 8'd1;
  localparam logic [15:0] PORT_HTTP   = 16'd80;
  localparam logic [15:0] PORT_FTP_D  = 16'd20;
  localparam logic [15:0] PORT_FTP_C  = 16'd21;
  localparam logic [15:0] PORT_SSH    = 16'd22;
  localparam logic [15:0] PORT_DNS    = 16'd53;

  logic [6:0]  pos_q, pos_d;
  logic [15:0] ether_q, ether_d;
  logic [3:0]  hdr_q, hdr_d;
  logic [7:0]  proto_q, proto_d;
  logic [15:0] sport_q, sport_d;
  logic [15:0] dport_q, dport_d;
  logic [7:0]  l4_pos, pos8, cnt;
  logic        sp_ok, dp_ok;

  function automatic logic port_hit(input logic sp_ok_a, input logic dp_ok_a,
                                    input logic [15:0] sp, input logic [15:0] dp,
                                    input logic [15:0] port);
    return (sp_ok_a && sp == port) || (dp_ok_a && dp == port);
  endfunction

  always_comb begin
    ether_d = ether_q;
    hdr_d   = hdr_q;
    proto_d = proto_q;
    sport_d = sport_q;
    dport_d = dport_q;
    pos_d   = pos_q;
    pos8    = {1'b0, pos_q};

    if (pos_q == POS_ETH_HI) ether_d[15:8] = data_byte_i;
    if (pos_q == POS_ETH_LO) ether_d[7:0]  = data_byte_i;
    if (pos_q == POS_IHL)    hdr_d         = data_byte_i[3:0];
    if (pos_q == POS_PROTO)  proto_d       = data_byte_i;

    // ports sit right after the IP header, placed by the fresh IHL
    l4_pos = IP_HDR_BASE + {2'b00, hdr_d, 2'b00};
    if (pos8 == l4_pos)         sport_d[15:8] = data_byte_i;
    if (pos8 == l4_pos + 8'd1)  sport_d[7:0]  = data_byte_i;
    if (pos8 == l4_pos + 8'd2)  dport_d[15:8] = data_byte_i;
    if (pos8 == l4_pos + 8'd3)  dport_d[7:0]  = data_byte_i;

    cnt   = pos8 + 8'd1;
    sp_ok = cnt >= l4_pos + 8'd2;
    dp_ok = cnt >= l4_pos + 8'd4;

    cls_o.l4  = L4_NOT_IP;
    cls_o.app = APP_NONE;
    if (cnt >= CNT_ETH && ether_d == ETH_IPV4) begin
      cls_o.l4 = L4_IP_OTHER;
      if (cnt >= CNT_PROTO) begin
        if (proto_d == PROTO_TCP) begin
          cls_o.l4 = L4_TCP;
          if (port_hit(sp_ok, dp_ok, sport_d, dport_d, PORT_HTTP)) begin
            cls_o.app = APP_HTTP;
          end else if (port_hit(sp_ok, dp_ok, sport_d, dport_d, PORT_FTP_D) ||
                       port_hit(sp_ok, dp_ok, sport_d, dport_d, PORT_FTP_C)) begin
            cls_o.app = APP_FTP;
          end else if (port_hit(sp_ok, dp_ok, sport_d, dport_d, PORT_SSH)) begin
            cls_o.app = APP_SSH;
          end else if (port_hit(sp_ok, dp_ok, sport_d, dport_d, PORT_DNS)) begin
            cls_o.app = APP_DNS;
          end
        end else if (proto_d == PROTO_UDP) begin
          cls_o.l4 = L4_UDP;
          if (port_hit(sp_ok, dp_ok, sport_d, dport_d, PORT_DNS)) cls_o.app = APP_DNS;
        end else if (proto_d == PROTO_ICMP) begin
          cls_o.l4 = L4_ICMP;
        end
      end
    end

    if (last_i) begin
      pos_d   = '0;
      ether_d = '0;
      hdr_d   = '0;
      proto_d = '0;
      sport_d = '0;
      dport_d = '0;
    end else if (pos_q != POS_MAX) begin
      pos_d = pos_q + 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      ether_q <= '0;
      hdr_q   <= '0;
      proto_q <= '0;
      sport_q <= '0;
      dport_q <= '0;
    end else if (byte_en_i) begin
      pos_q   <= pos_d;
      ether_q <= ether_d;
      hdr_q   <= hdr_d;
      proto_q <= proto_d;
      sport_q <= sport_d;
      dport_q <= dport_d;
    end
  end

endmodule

FILE: rtl/pcc_stats.sv
`timescale 1ns / 1ps

module pcc_stats #(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pcc_pkg::upd_req_t        upd_i,
  input  logic                     rd_en_i,
  input  logic [3:0]               rd_idx_i,
  output logic [COUNTER_WIDTH-1:0] rd_value_o
);
  import pcc_pkg::*;

  localparam int unsigned ROW_W = 2 * COUNTER_WIDTH;

  logic [ROW_W-1:0] mem [NUM_ROWS];
  logic [NUM_ROWS-1:0] row_vld_q;

  // update pipe: issue -> modify/write
  logic             s1_valid_q;
  row_t             s1_row_q;
  logic [LEN_W-1:0] s1_len_q;
  logic [ROW_W-1:0] upd_rd_q;
  logic             upd_vld_q;
  logic             wb_valid_q;
  row_t             wb_row_q;
  logic [ROW_W-1:0] wb_data_q;
  logic [ROW_W-1:0] cur_row, new_row;

  // statistics read port
  row_t             rd_row;
  logic [ROW_W-1:0] cnt_rd_q;
  logic             cnt_vld_q;
  logic             fwd_hit_q;
  logic [ROW_W-1:0] fwd_q;
  logic             sel_hi_q;
  logic [ROW_W-1:0] rd_row_val;

  assign rd_row = rd_idx_i[3:1];

  always_comb begin
    if (wb_valid_q && wb_row_q == s1_row_q) begin
      cur_row = wb_data_q;
    end else if (upd_vld_q) begin
      cur_row = upd_rd_q;
    end else begin
      cur_row = '0;
    end
    new_row[COUNTER_WIDTH-1:0]     = cur_row[COUNTER_WIDTH-1:0] + COUNTER_WIDTH'(1);
    new_row[ROW_W-1:COUNTER_WIDTH] = cur_row[ROW_W-1:COUNTER_WIDTH]
                                   + COUNTER_WIDTH'(s1_len_q);
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) mem[s1_row_q] <= new_row;
    upd_rd_q  <= mem[upd_i.row];
    s1_len_q  <= upd_i.len;
    s1_row_q  <= upd_i.row;
    wb_row_q  <= s1_row_q;
    wb_data_q <= new_row;
    if (rd_en_i) begin
      cnt_rd_q <= mem[rd_row];
      fwd_q    <= new_row;
      sel_hi_q <= rd_idx_i[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q  <= '0;
      s1_valid_q <= 1'b0;
      upd_vld_q  <= 1'b0;
      wb_valid_q <= 1'b0;
      cnt_vld_q  <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      if (s1_valid_q) row_vld_q[s1_row_q] <= 1'b1;
      s1_valid_q <= upd_i.valid;
      upd_vld_q  <= row_vld_q[upd_i.row];
      wb_valid_q <= s1_valid_q;
      if (rd_en_i) begin
        cnt_vld_q <= row_vld_q[rd_row];
        // a write landing on the same edge is not yet in the array
        fwd_hit_q <= s1_valid_q && s1_row_q == rd_row;
      end
    end
  end

  always_comb begin
    if (fwd_hit_q) begin
      rd_row_val = fwd_q;
    end else if (cnt_vld_q) begin
      rd_row_val = cnt_rd_q;
    end else begin
      rd_row_val = '0;
    end
    rd_value_o = sel_hi_q ? rd_row_val[ROW_W-1:COUNTER_WIDTH]
                          : rd_row_val[COUNTER_WIDTH-1:0];
  end

endmodule

FILE: rtl/packet_class_counter.sv
`timescale 1ns / 1ps
// A classification or counter read result is registered and offered in the cycle after the transfer.
// Throughput: 1 transfer per cycle; a last byte or counter read waits for a free output
//   and, after a frame that hits class counters, while the extra rows are updated.
// Counters live in an 8-row memory, one read-modify-write per cycle on its update port.
// Reset (async, active low) clears the parser, the pending updates and the row valid bits.

module packet_class_counter #(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  pcc_in_if.sink   in_i,
  pcc_out_if.source out_o
);
  import pcc_pkg::*;

  logic in_xfer, byte_xfer, frame_end, read_xfer;
  logic needs_slot, out_free;
  cls_t cls;

  // rows still owed by the last finished frame
  logic             pend_l4_q, pend_app_q;
  row_t             pend_l4_row_q, pend_app_row_q;
  logic [LEN_W-1:0] pend_len_q;
  logic             pend_any;
  logic             l4_hit, app_hit;
  row_t             l4_row, app_row;

  upd_req_t upd;

  // output register
  logic       out_valid_q;
  kind_e      kind_q;
  l4_class_e  l4_q;
  app_class_e app_q;
  logic [COUNTER_WIDTH-1:0] cnt_value;

  assign pend_any  = pend_l4_q || pend_app_q;
  assign out_free  = !out_valid_q || out_o.ready;
  // frame bytes that are not last make no result and need no update slot
  assign needs_slot = (in_i.op == OP_READ) || in_i.last;
  assign in_i.ready = !needs_slot || (!pend_any && out_free);

  assign in_xfer   = in_i.valid && in_i.ready;
  assign byte_xfer = in_xfer && in_i.op == OP_BYTE;
  assign frame_end = byte_xfer && in_i.last;
  assign read_xfer = in_xfer && in_i.op == OP_READ;

  pcc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_en_i   (byte_xfer),
    .data_byte_i (in_i.data_byte),
    .last_i      (in_i.last),
    .cls_o       (cls)
  );

  always_comb begin
    l4_hit = 1'b1;
    l4_row = ROW_TCP;
    case (cls.l4)
      L4_TCP:  l4_row = ROW_TCP;
      L4_UDP:  l4_row = ROW_UDP;
      L4_ICMP: l4_row = ROW_ICMP;
      default: l4_hit = 1'b0;
    endcase
    app_hit = 1'b1;
    app_row = ROW_HTTP;
    case (cls.app)
      APP_HTTP: app_row = ROW_HTTP;
      APP_FTP:  app_row = ROW_FTP;
      APP_SSH:  app_row = ROW_SSH;
      APP_DNS:  app_row = ROW_DNS;
      default:  app_hit = 1'b0;
    endcase
  end

  // Update slot: the all-frames row on the last byte, else drain pending rows.
  // Pending rows never meet a last byte: ready holds those off.
  always_comb begin
    upd.valid = 1'b0;
    upd.row   = ROW_ALL;
    upd.len   = pend_len_q;
    if (frame_end) begin
      upd.valid = 1'b1;
      upd.len   = in_i.frame_len;
    end else if (pend_l4_q) begin
      upd.valid = 1'b1;
      upd.row   = pend_l4_row_q;
    end else if (pend_app_q) begin
      upd.valid = 1'b1;
      upd.row   = pend_app_row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_l4_q  <= 1'b0;
      pend_app_q <= 1'b0;
    end else if (frame_end) begin
      pend_l4_q  <= l4_hit;
      pend_app_q <= app_hit;
    end else if (pend_l4_q) begin
      pend_l4_q <= 1'b0;
    end else begin
      pend_app_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_end) begin
      pend_l4_row_q  <= l4_row;
      pend_app_row_q <= app_row;
      pend_len_q     <= in_i.frame_len;
    end
  end

  pcc_stats #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_stats (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (upd),
    .rd_en_i    (read_xfer),
    .rd_idx_i   (in_i.counter_index),
    .rd_value_o (cnt_value)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      kind_q      <= KIND_CLASS;
      l4_q        <= L4_NOT_IP;
      app_q       <= APP_NONE;
    end else if (frame_end) begin
      out_valid_q <= 1'b1;
      kind_q      <= KIND_CLASS;
      l4_q        <= cls.l4;
      app_q       <= cls.app;
    end else if (read_xfer) begin
      out_valid_q <= 1'b1;
      kind_q      <= KIND_COUNT;
      l4_q        <= L4_NOT_IP;
      app_q       <= APP_NONE;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = kind_q;
  assign out_o.l4_class    = l4_q;
  assign out_o.app_class   = app_q;
  // low 32 bits of the counter; the read register holds while the result waits
  assign out_o.count_value = (kind_q == KIND_COUNT) ? 32'(cnt_value) : 32'd0;

endmodule
